// ===== hdl/dpd_pkg.sv =====
// shared types, codes and digit decoding for the debug packet deframer
package dpd_pkg;

   // framing characters
   localparam logic [7:0] CHAR_ACK   = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_START = 8'h24;  // '$'
   localparam logic [7:0] CHAR_END   = 8'h23;  // '#'

   localparam logic [3:0] NIBBLE_MASK = 4'hF;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   // result kinds
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_GOOD    = 3'd1;
   localparam logic [2:0] KIND_BAD     = 3'd2;
   localparam logic [2:0] KIND_NOACK   = 3'd3;
   localparam logic [2:0] KIND_NOSTART = 3'd4;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_count;
   } result_type;

   // hex digit to value; anything else passes through as itself
   function automatic logic [7:0] digit_value(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = b - 8'h37;
      end
      return v;
   endfunction

endpackage

// ===== hdl/dpd_stream_if.sv =====
// valid/ready channel interfaces for received bytes and results
interface dpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] byte_count;

   modport source (output valid, output kind, output data_byte, output byte_count,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_count,
                   output ready);
endinterface

// ===== hdl/dpd_in_reg.sv =====
// input register holding one received byte
module dpd_in_reg (
   input  logic         clock,
   input  logic         reset,
   dpd_req_if.sink      req_chan,
   input  logic         out_free,
   output logic         advance,
   output logic [7:0]   byte_q
);

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign advance        = valid_ff && out_free;
   assign req_chan.ready = !valid_ff || advance;
   assign byte_q         = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

endmodule

// ===== hdl/dpd_core.sv =====
// framing state, running checksum and payload count
module dpd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            byte_q,
   output dpd_pkg::result_type   result
);

   typedef enum logic [2:0] {
      PH_ACK     = 3'd0,
      PH_START   = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_HI      = 3'd3,
      PH_LO      = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic        match_ff, match_in;
   logic [15:0] count_ff, count_in;

   always_comb begin
      logic good;
      good              = 1'b0;
      phase_in          = phase_ff;
      sum_in            = sum_ff;
      match_in          = match_ff;
      count_in          = count_ff;
      result.valid      = 1'b0;
      result.kind       = dpd_pkg::KIND_DATA;
      result.data_byte  = 8'd0;
      result.byte_count = 16'd0;
      if (advance) begin
         case (phase_ff)
            PH_START: begin
               if (byte_q == dpd_pkg::CHAR_START) begin
                  sum_in   = 8'd0;
                  match_in = 1'b0;
                  count_in = 16'd0;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in     = PH_ACK;
                  result.valid = 1'b1;
                  result.kind  = dpd_pkg::KIND_NOSTART;
               end
            end
            PH_PAYLOAD: begin
               if (byte_q == dpd_pkg::CHAR_END) begin
                  phase_in = PH_HI;
               end else begin
                  sum_in = sum_ff + byte_q;
                  if (count_ff != dpd_pkg::COUNT_MAX) begin
                     count_in = count_ff + 16'd1;
                  end
                  result.valid     = 1'b1;
                  result.kind      = dpd_pkg::KIND_DATA;
                  result.data_byte = byte_q;
               end
            end
            PH_HI: begin
               match_in = (dpd_pkg::digit_value(byte_q) ==
                           {4'h0, sum_ff[7:4] & dpd_pkg::NIBBLE_MASK});
               phase_in = PH_LO;
            end
            PH_LO: begin
               good = match_ff && (dpd_pkg::digit_value(byte_q) ==
                                   {4'h0, sum_ff[3:0] & dpd_pkg::NIBBLE_MASK});
               result.valid      = 1'b1;
               result.kind       = good ? dpd_pkg::KIND_GOOD : dpd_pkg::KIND_BAD;
               result.byte_count = count_ff;
               sum_in            = 8'd0;
               match_in          = 1'b0;
               count_in          = 16'd0;
               phase_in          = PH_ACK;
            end
            default: begin
               // waiting for acknowledge; unused codes land here too
               if (byte_q == dpd_pkg::CHAR_ACK) begin
                  phase_in = PH_START;
               end else begin
                  phase_in     = PH_ACK;
                  result.valid = 1'b1;
                  result.kind  = dpd_pkg::KIND_NOACK;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ACK;
         sum_ff   <= 8'd0;
         match_ff <= 1'b0;
         count_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         match_ff <= match_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/dpd_out_reg.sv =====
// result register driving the response channel
module dpd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  dpd_pkg::result_type  result,
   output logic                 out_free,
   dpd_rsp_if.source            rsp_chan
);

   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic [7:0]  data_ff;
   logic [15:0] count_ff;

   assign out_free            = !valid_ff || rsp_chan.ready;
   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.data_byte  = data_ff;
   assign rsp_chan.byte_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) begin
         kind_ff  <= result.kind;
         data_ff  <= result.data_byte;
         count_ff <= result.byte_count;
      end
   end

endmodule

// ===== hdl/debug_packet_deframer.sv =====
// top level of the debug packet deframer
//
//   channel   dir   handshake         payload
//   req_chan  in    valid / ready     rx_byte[7:0]
//   rsp_chan  out   valid / ready     kind[2:0], data_byte[7:0], byte_count[15:0]
//
// one byte per cycle while rsp_chan does not stall; a byte is held in the input
// register and its result in the result register
// at most one result per byte; the end mark and high checksum digit give none
// synchronous active-high reset returns to waiting for acknowledge
// a stalled result holds the input register, which then backs up req_chan
module debug_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   dpd_req_if.sink     req_chan,
   dpd_rsp_if.source   rsp_chan
);

   logic                out_free;
   logic                advance;
   logic [7:0]          byte_q;
   dpd_pkg::result_type result;

   dpd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .advance  (advance),
      .byte_q   (byte_q)
   );

   dpd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .byte_q  (byte_q),
      .result  (result)
   );

   dpd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hdl/dpd_checker.sv =====
// port-level checks for the debug packet deframer and their binding
module dpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_byte_count
);

   // no result may be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // only payload items carry a data byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != dpd_pkg::KIND_DATA) |-> rsp_data_byte == 8'd0)
      else $error("data byte set on a status item");

   // only checksum status carries a count
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != dpd_pkg::KIND_GOOD && rsp_kind != dpd_pkg::KIND_BAD)
      |-> rsp_byte_count == 16'd0)
      else $error("byte count set on a non-checksum item");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) &&
       $stable(rsp_byte_count)))
      else $error("stalled result changed");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_data_byte  (rsp_chan.data_byte),
   .rsp_byte_count (rsp_chan.byte_count)
);

// ===== tb/debug_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the debug packet deframer with random idling on both channels
module debug_packet_deframer_tb;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_BYTES = 1270;
   localparam int BURST_PACKET = 48;
   localparam int MAX_IDLE     = 13;
   localparam int TAIL_CYCLES  = 16;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SHOW_LIMIT   = 10;

   typedef enum logic [2:0] {
      AWAIT_ACK, AWAIT_START, IN_PAYLOAD, HIGH_DIGIT, LOW_DIGIT
   } frame_phase_type;

   typedef struct {
      logic [7:0] value;
      bit         eager;
   } link_byte_type;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_count;
   } deframed_type;

   logic clock;
   logic reset;

   dpd_req_if req_chan ();
   dpd_rsp_if rsp_chan ();

   debug_packet_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   link_byte_type link_bytes[$];
   deframed_type  expected_results[$];

   // predictor state
   frame_phase_type frame_phase;
   logic [7:0]      frame_sum;
   logic            high_ok;
   logic [15:0]     frame_count;

   int            total_bytes;
   int            bytes_accepted;
   int            send_gap;
   int            hold_cycles;
   bit            calm_send;
   bit            calm_recv;
   bit            rush;
   link_byte_type next_byte;
   deframed_type  want;
   int            cycle_count;
   int            mismatches;
   int            results_seen;
   int            payload_seen;
   int            good_seen;
   int            bad_seen;
   int            framing_seen;

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [7:0] hex_value(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return ch - "0";
      if (ch >= "a" && ch <= "f") return ch - "a" + 8'd10;
      if (ch >= "A" && ch <= "F") return ch - "A" + 8'd10;
      return ch;
   endfunction

   task automatic deframe_byte(input logic [7:0] ch);
      deframed_type r;
      bit           has_result;
      has_result = 1'b0;
      r = '{dpd_pkg::KIND_DATA, 8'h00, 16'h0000};
      case (frame_phase)
         AWAIT_START: begin
            if (ch == dpd_pkg::CHAR_START) begin
               frame_sum = 8'h00;
               high_ok = 1'b0;
               frame_count = 16'h0000;
               frame_phase = IN_PAYLOAD;
            end else begin
               r.kind = dpd_pkg::KIND_NOSTART;
               has_result = 1'b1;
               frame_phase = AWAIT_ACK;
            end
         end
         IN_PAYLOAD: begin
            if (ch == dpd_pkg::CHAR_END) begin
               frame_phase = HIGH_DIGIT;
            end else begin
               frame_sum = frame_sum + ch;
               if (frame_count != dpd_pkg::COUNT_MAX) frame_count = frame_count + 16'd1;
               r.data_byte = ch;
               has_result = 1'b1;
            end
         end
         HIGH_DIGIT: begin
            high_ok = (hex_value(ch) == {4'h0, frame_sum[7:4]});
            frame_phase = LOW_DIGIT;
         end
         LOW_DIGIT: begin
            r.kind = (high_ok && hex_value(ch) == {4'h0, frame_sum[3:0]}) ?
                     dpd_pkg::KIND_GOOD : dpd_pkg::KIND_BAD;
            r.byte_count = frame_count;
            has_result = 1'b1;
            frame_sum = 8'h00;
            high_ok = 1'b0;
            frame_count = 16'h0000;
            frame_phase = AWAIT_ACK;
         end
         default: begin
            // stray phase codes behave as waiting for acknowledge
            if (ch == dpd_pkg::CHAR_ACK) begin
               frame_phase = AWAIT_START;
            end else begin
               r.kind = dpd_pkg::KIND_NOACK;
               has_result = 1'b1;
               frame_phase = AWAIT_ACK;
            end
         end
      endcase
      if (has_result) expected_results.push_back(r);
   endtask

   // one of the spellings that decode to the nibble: lower, upper or raw value
   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      case ($urandom_range(0, 2))
         0: return (n < 4'd10) ? 8'h30 + n : 8'h61 + n - 8'd10;
         1: return (n < 4'd10) ? 8'h30 + n : 8'h41 + n - 8'd10;
         default: return {4'h0, n};
      endcase
   endfunction

   function automatic logic [7:0] wrong_char(input logic [3:0] n);
      logic [7:0] ch;
      if ($urandom_range(0, 1) == 0) return nibble_char(n ^ 4'($urandom_range(1, 15)));
      // a byte of 16 or more that is no hex digit never matches
      do ch = 8'($urandom_range(16, 255)); while (hex_value(ch) < 16);
      return ch;
   endfunction

   task automatic push_byte(input logic [7:0] v, input bit eager);
      link_byte_type lb;
      lb.value = v;
      lb.eager = eager;
      link_bytes.push_back(lb);
   endtask

   task automatic add_packet(input int len, input bit eager);
      logic [7:0] sum;
      logic [7:0] ch;
      int         style;
      sum = 8'h00;
      push_byte(dpd_pkg::CHAR_ACK, eager);
      push_byte(dpd_pkg::CHAR_START, eager);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0: ch = dpd_pkg::CHAR_ACK;
            1: ch = dpd_pkg::CHAR_START;
            default: ch = 8'($urandom_range(0, 255));
         endcase
         if (ch == dpd_pkg::CHAR_END) ch = ~ch;
         sum = sum + ch;
         push_byte(ch, eager);
      end
      push_byte(dpd_pkg::CHAR_END, eager);
      style = eager ? 0 : $urandom_range(0, 9);
      case (style)
         6: begin
            push_byte(wrong_char(sum[7:4]), eager);
            push_byte(nibble_char(sum[3:0]), eager);
         end
         7: begin
            push_byte(nibble_char(sum[7:4]), eager);
            push_byte(wrong_char(sum[3:0]), eager);
         end
         8: begin
            push_byte(wrong_char(sum[7:4]), eager);
            push_byte(wrong_char(sum[3:0]), eager);
         end
         9: begin
            push_byte(8'($urandom_range(0, 255)), eager);
            push_byte(8'($urandom_range(0, 255)), eager);
         end
         default: begin
            push_byte(nibble_char(sum[7:4]), eager);
            push_byte(nibble_char(sum[3:0]), eager);
         end
      endcase
   endtask

   task automatic add_noise();
      logic [7:0] ch;
      case ($urandom_range(0, 2))
         0: begin
            ch = 8'($urandom_range(0, 255));
            if (ch == dpd_pkg::CHAR_ACK) ch = ~ch;
            push_byte(ch, 1'b0);
         end
         1: begin
            ch = 8'($urandom_range(0, 255));
            if (ch == dpd_pkg::CHAR_START) ch = ~ch;
            push_byte(dpd_pkg::CHAR_ACK, 1'b0);
            push_byte(ch, 1'b0);
         end
         default: begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            // end mark and two zeros bring any phase back to waiting for acknowledge
            push_byte(dpd_pkg::CHAR_END, 1'b0);
            push_byte("0", 1'b0);
            push_byte("0", 1'b0);
         end
      endcase
   endtask

   // byte driver and predictor feed
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
         frame_phase = AWAIT_ACK;
         frame_sum = 8'h00;
         high_ok = 1'b0;
         frame_count = 16'h0000;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            deframe_byte(req_chan.rx_byte);
            bytes_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (link_bytes.size() != 0) begin
               next_byte = link_bytes.pop_front();
               req_chan.rx_byte <= next_byte.value;
               req_chan.valid <= 1'b1;
               if ($urandom_range(0, 47) == 0) calm_send = !calm_send;
               send_gap = (next_byte.eager || calm_send) ? 0 : $urandom_range(0, MAX_IDLE);
               rush <= next_byte.eager;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles = 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         case (rsp_chan.kind)
            dpd_pkg::KIND_DATA: payload_seen++;
            dpd_pkg::KIND_GOOD: good_seen++;
            dpd_pkg::KIND_BAD:  bad_seen++;
            default:            framing_seen++;
         endcase
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected result %0d: kind %0d data %02h count %0d", results_seen,
                        rsp_chan.kind, rsp_chan.data_byte, rsp_chan.byte_count);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.kind !== want.kind || rsp_chan.data_byte !== want.data_byte ||
                rsp_chan.byte_count !== want.byte_count) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("mismatch at result %0d: got kind %0d data %02h count %0d, %s",
                           results_seen, rsp_chan.kind, rsp_chan.data_byte,
                           rsp_chan.byte_count,
                           $sformatf("want kind %0d data %02h count %0d", want.kind,
                                     want.data_byte, want.byte_count));
            end
         end
         if ($urandom_range(0, 47) == 0) calm_recv = !calm_recv;
         hold_cycles = (rush || calm_recv) ? 0 : $urandom_range(0, MAX_IDLE);
         rsp_chan.ready <= (hold_cycles == 0);
      end else if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_chan.ready <= (hold_cycles == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("FAIL debug_packet_deframer");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      rush = 1'b0;

      // missing acknowledge at both byte extremes
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      // missing start
      push_byte(dpd_pkg::CHAR_ACK, 1'b0);
      push_byte(8'hFF, 1'b0);
      // empty payload, good checksum
      push_byte(dpd_pkg::CHAR_ACK, 1'b0);
      push_byte(dpd_pkg::CHAR_START, 1'b0);
      push_byte(dpd_pkg::CHAR_END, 1'b0);
      push_byte("0", 1'b0);
      push_byte("0", 1'b0);
      // sum ff with mixed-case digits
      push_byte(dpd_pkg::CHAR_ACK, 1'b0);
      push_byte(dpd_pkg::CHAR_START, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(dpd_pkg::CHAR_END, 1'b0);
      push_byte("f", 1'b0);
      push_byte("F", 1'b0);
      // raw low byte values match nibbles
      push_byte(dpd_pkg::CHAR_ACK, 1'b0);
      push_byte(dpd_pkg::CHAR_START, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(dpd_pkg::CHAR_END, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b0);
      // non-hex high digit gives a bad checksum
      push_byte(dpd_pkg::CHAR_ACK, 1'b0);
      push_byte(dpd_pkg::CHAR_START, 1'b0);
      push_byte(dpd_pkg::CHAR_END, 1'b0);
      push_byte("g", 1'b0);
      push_byte("0", 1'b0);
      // one packet sent back to back with no idling on either side
      add_packet(BURST_PACKET, 1'b1);

      total_bytes = link_bytes.size() + RANDOM_BYTES;
      while (link_bytes.size() < total_bytes) begin
         if ($urandom_range(0, 9) == 0) add_noise();
         else if ($urandom_range(0, 15) == 0) add_packet($urandom_range(17, 64), 1'b0);
         else add_packet($urandom_range(0, 16), 1'b0);
      end
      total_bytes = link_bytes.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_accepted == total_bytes);
      wait (expected_results.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d cycles, checked %0d results", total_bytes, cycle_count,
               results_seen);
      $display("payload %0d, good %0d, bad %0d, framing errors %0d, mismatches %0d",
               payload_seen, good_seen, bad_seen, framing_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS debug_packet_deframer");
      end else begin
         $display("FAIL debug_packet_deframer");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/dpd_pkg.sv
hdl/dpd_stream_if.sv
hdl/dpd_in_reg.sv
hdl/dpd_core.sv
hdl/dpd_out_reg.sv
hdl/debug_packet_deframer.sv
hdl/dpd_checker.sv
tb/debug_packet_deframer_tb.sv
